>>> rtl/core/hrf_pkg.sv
package hrf_pkg;

  localparam int KEY_LEN = 15;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
    8'h6c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a
  };

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // CR LF CR LF progress
  localparam logic [2:0] BLANK_IDLE = 3'd0;
  localparam logic [2:0] BLANK_CR1 = 3'd1;
  localparam logic [2:0] BLANK_LF1 = 3'd2;
  localparam logic [2:0] BLANK_CR2 = 3'd3;
  localparam logic [2:0] BLANK_DONE = 3'd4;

  typedef enum logic [0:0] {
    CFG_MAX_HEADER   = 1'b0,
    CFG_MAX_BUFFERED = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_NEED_MORE  = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_HDR_LARGE  = 2'd2,
    ST_TOO_MUCH   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_KEY    = 2'd0,
    PH_BLANK  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // classified byte, handed from front to back
  typedef struct packed {
    logic        is_cr;
    logic        is_lf;
    logic        is_blank;
    logic        is_digit;
    logic [3:0]  digit;
    logic [15:0] key_hit;  // bit i: lowercased byte equals key char i
  } hrf_class_t;

endpackage

>>> rtl/core/hrf_front.sv
module hrf_front import hrf_pkg::*; (
  input  logic [7:0]  byte_in,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        q_full,
  output logic        push,
  output hrf_class_t  item
);

  logic [7:0] low;

  always_comb begin
    low = (byte_in >= CHAR_UA && byte_in <= CHAR_UZ) ? byte_in + CASE_OFS : byte_in;
    item.is_cr = (byte_in == CHAR_CR);
    item.is_lf = (byte_in == CHAR_LF);
    item.is_blank = (byte_in == CHAR_SP) || (byte_in == CHAR_TAB);
    item.is_digit = (byte_in >= CHAR_0) && (byte_in <= CHAR_9);
    item.digit = byte_in[3:0];
    item.key_hit = '0;
    for (int i = 0; i < KEY_LEN; i++) begin
      item.key_hit[i] = (low == KEY_TEXT[i]);
    end
  end

  assign in_stall = q_full;
  assign push = in_valid && !q_full;

endmodule

>>> rtl/core/hrf_queue.sv
module hrf_queue import hrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  hrf_class_t  wr_item,
  input  logic        pop,
  output hrf_class_t  rd_item,
  output logic        avail,
  output logic        full
);

  hrf_class_t          mem [QDEPTH];
  logic [QAW-1:0]      wr_ptr;
  logic [QAW-1:0]      rd_ptr;
  logic [QAW:0]        fill;

  assign rd_item = mem[rd_ptr];
  assign avail = (fill != '0);
  assign full = (fill == (QAW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: fill <= fill + 1'b1;
        2'b01: fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/core/hrf_back.sv
module hrf_back import hrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  hrf_class_t  item,
  input  logic        avail,
  output logic        pop,
  input  logic [15:0] max_header_bytes,
  input  logic [31:0] max_buffered_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] request_length,
  output logic [15:0] header_length,
  output logic [63:0] body_length
);

  logic [2:0]  blank_line_match, blank_line_match_next;
  logic [3:0]  key_match, key_match_next;
  phase_t      value_phase, value_phase_next;
  logic [63:0] length_value, length_value_next;
  logic        length_overflow, length_overflow_next;
  logic [31:0] count, count_next;  // count of the byte being handled
  logic        headers_done, headers_done_next;
  logic [15:0] hdr_size, hdr_size_next;
  logic [63:0] total, total_next;

  logic [63:0] cl;
  logic [15:0] hs_sel;
  logic [64:0] sum;
  logic [63:0] total_sel;
  logic [67:0] prod;
  logic        do_acc;
  logic        judge;
  logic        clear;
  status_t     res_status;
  logic [31:0] res_req;
  logic [15:0] res_hdr;
  logic [63:0] res_body;

  assign pop = avail && (!out_valid || !out_stall);

  always_comb begin
    blank_line_match_next = blank_line_match;
    key_match_next = key_match;
    value_phase_next = value_phase;
    length_value_next = length_value;
    length_overflow_next = length_overflow;
    headers_done_next = headers_done;
    hdr_size_next = hdr_size;
    total_next = total;
    do_acc = 1'b0;
    judge = 1'b0;
    clear = 1'b0;
    res_status = ST_NEED_MORE;
    res_req = '0;
    res_hdr = '0;
    res_body = '0;

    cl = length_overflow ? 64'd0 : length_value;
    hs_sel = headers_done ? hdr_size : count[15:0];
    sum = {1'b0, cl} + {49'd0, hs_sel};
    total_sel = headers_done ? total : (sum[64] ? '1 : sum[63:0]);
    prod = ({4'd0, length_value} << 3) + ({4'd0, length_value} << 1) + {64'd0, item.digit};

    if (!headers_done) begin
      if (item.is_cr) begin
        blank_line_match_next = (blank_line_match == BLANK_LF1) ? BLANK_CR2 : BLANK_CR1;
      end else if (item.is_lf) begin
        if (blank_line_match == BLANK_CR1) begin
          blank_line_match_next = BLANK_LF1;
        end else if (blank_line_match == BLANK_CR2) begin
          blank_line_match_next = BLANK_DONE;
        end else begin
          blank_line_match_next = BLANK_IDLE;
        end
      end else begin
        blank_line_match_next = BLANK_IDLE;
      end

      case (value_phase)
        PH_KEY: begin
          if (item.key_hit[key_match]) begin
            key_match_next = key_match + 1'b1;
          end else begin
            key_match_next = {3'd0, item.key_hit[0]};
          end
          if (key_match_next == 4'(KEY_LEN)) begin
            value_phase_next = PH_BLANK;
          end
        end
        PH_BLANK: begin
          if (!item.is_blank) begin
            if (item.is_digit) begin
              value_phase_next = PH_DIGITS;
              do_acc = 1'b1;
            end else begin
              value_phase_next = PH_DONE;
            end
          end
        end
        PH_DIGITS: begin
          if (item.is_digit) begin
            do_acc = 1'b1;
          end else begin
            value_phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      if (do_acc) begin
        if (prod[67:64] != 4'd0) begin
          length_overflow_next = 1'b1;
        end else begin
          length_value_next = prod[63:0];
        end
      end

      if (count > {16'd0, max_header_bytes}) begin
        res_status = ST_HDR_LARGE;
        clear = 1'b1;
      end else if (blank_line_match_next == BLANK_DONE) begin
        // this byte closed the header; cl is unaffected by a line feed
        judge = 1'b1;
        headers_done_next = 1'b1;
        hdr_size_next = count[15:0];
      end
    end else begin
      judge = 1'b1;
    end

    if (judge) begin
      res_hdr = hs_sel;
      res_body = cl;
      total_next = total_sel;
      if ({32'd0, count} >= total_sel) begin
        res_status = ST_COMPLETE;
        res_req = total_sel[31:0];
        clear = 1'b1;
      end else if (total_sel > {32'd0, max_buffered_bytes}) begin
        res_status = ST_TOO_MUCH;
        clear = 1'b1;
      end
    end

    count_next = count + 32'd1;
    if (clear) begin
      blank_line_match_next = BLANK_IDLE;
      key_match_next = '0;
      value_phase_next = PH_KEY;
      length_value_next = '0;
      length_overflow_next = 1'b0;
      headers_done_next = 1'b0;
      hdr_size_next = '0;
      count_next = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_line_match <= BLANK_IDLE;
      key_match <= '0;
      value_phase <= PH_KEY;
      length_value <= '0;
      length_overflow <= 1'b0;
      count <= 32'd1;
      headers_done <= 1'b0;
      hdr_size <= '0;
      total <= '0;
    end else if (pop) begin
      blank_line_match <= blank_line_match_next;
      key_match <= key_match_next;
      value_phase <= value_phase_next;
      length_value <= length_value_next;
      length_overflow <= length_overflow_next;
      count <= count_next;
      headers_done <= headers_done_next;
      hdr_size <= hdr_size_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status <= res_status;
      request_length <= res_req;
      header_length <= res_hdr;
      body_length <= res_body;
    end
  end

endmodule

>>> rtl/core/http_request_framer.sv
// Throughput: one byte per cycle while in_stall is low; a 4-entry queue
// between the classifier and the framing unit absorbs output stalls before
// input stall rises; the framing unit registers a result for each byte.
// Reset (rst, synchronous): queue and output emptied, framing state cleared,
// max_header_bytes = 8192, max_buffered_bytes = 1048576.
module http_request_framer import hrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  byte_in,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [1:0]  status,
  output logic [31:0] request_length,
  output logic [15:0] header_length,
  output logic [63:0] body_length,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0] max_header_bytes;
  logic [31:0] max_buffered_bytes;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_avail;
  hrf_class_t  wr_item;
  hrf_class_t  rd_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_header_bytes <= 16'd8192;
      max_buffered_bytes <= 32'd1048576;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAX_HEADER: max_header_bytes <= cfg_data[15:0];
        CFG_MAX_BUFFERED: max_buffered_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hrf_front u_front (
    .byte_in  (byte_in),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .item     (wr_item)
  );

  hrf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .avail   (q_avail),
    .full    (q_full)
  );

  hrf_back u_back (
    .clk                (clk),
    .rst                (rst),
    .item               (rd_item),
    .avail              (q_avail),
    .pop                (pop),
    .max_header_bytes   (max_header_bytes),
    .max_buffered_bytes (max_buffered_bytes),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .request_length     (request_length),
    .header_length      (header_length),
    .body_length        (body_length)
  );

endmodule

>>> sim/tb_http_request_framer.sv
module tb_http_request_framer;
  import hrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    status_t     st;
    logic [31:0] req_len;
    logic [15:0] hdr_len;
    logic [63:0] body_len;
  } frame_result_t;

  // Framing predictor plus the queue of per-beat results it expects.
  class framer_scoreboard;
    logic [15:0]   hdr_limit;
    logic [31:0]   buf_limit;
    logic [2:0]    crlf_prog;
    int            key_pos;
    phase_t        vphase;
    logic [63:0]   cl_acc;
    bit            cl_ovf;
    logic [31:0]   nbytes;
    bit            in_body;
    logic [15:0]   hdr_size;
    frame_result_t want_q[$];
    int            fails;
    int            shown;

    function new();
      hdr_limit = 16'd8192;
      buf_limit = 32'd1048576;
      fails = 0;
      shown = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crlf_prog = BLANK_IDLE;
      key_pos = 0;
      vphase = PH_KEY;
      cl_acc = '0;
      cl_ovf = 1'b0;
      nbytes = '0;
      in_body = 1'b0;
      hdr_size = '0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0]    low;
      bit            dig;
      logic [31:0]   cnt;
      logic [64:0]   sum;
      logic [63:0]   total;
      logic [63:0]   cl;
      logic [67:0]   grown;
      frame_result_t r;
      low = (b >= CHAR_UA && b <= CHAR_UZ) ? b + CASE_OFS : b;
      dig = (b >= CHAR_0 && b <= CHAR_9);
      cnt = nbytes + 32'd1;
      nbytes = cnt;
      r = '{ST_NEED_MORE, 32'h0, 16'h0, 64'h0};
      if (!in_body) begin
        if (b == CHAR_CR) begin
          crlf_prog = (crlf_prog == BLANK_LF1) ? BLANK_CR2 : BLANK_CR1;
        end else if (b == CHAR_LF) begin
          if (crlf_prog == BLANK_CR1) crlf_prog = BLANK_LF1;
          else if (crlf_prog == BLANK_CR2) crlf_prog = BLANK_DONE;
          else crlf_prog = BLANK_IDLE;
        end else begin
          crlf_prog = BLANK_IDLE;
        end
        if (vphase == PH_KEY) begin
          if (key_pos < KEY_LEN && low == KEY_TEXT[key_pos]) key_pos++;
          else key_pos = (low == KEY_TEXT[0]) ? 1 : 0;
          if (key_pos >= KEY_LEN) vphase = PH_BLANK;
        end else if (!(vphase == PH_BLANK && (b == CHAR_SP || b == CHAR_TAB))) begin
          if (vphase == PH_BLANK) vphase = dig ? PH_DIGITS : PH_DONE;
          if (vphase == PH_DIGITS) begin
            if (!dig) begin
              vphase = PH_DONE;
            end else begin
              // overflow latches; the value keeps its last in-range digits
              grown = cl_acc * 68'd10 + (b - CHAR_0);
              if (grown > 68'hFFFF_FFFF_FFFF_FFFF) cl_ovf = 1'b1;
              else cl_acc = grown[63:0];
            end
          end
        end
        if (cnt > hdr_limit) begin
          r.st = ST_HDR_LARGE;
          clear_frame();
          want_q.insert(want_q.size(), r);
          return;
        end
        if (crlf_prog != BLANK_DONE) begin
          want_q.insert(want_q.size(), r);
          return;
        end
        in_body = 1'b1;
        hdr_size = cnt[15:0];
      end
      cl = cl_ovf ? 64'h0 : cl_acc;
      sum = {1'b0, cl} + hdr_size;
      total = sum[64] ? '1 : sum[63:0];
      r.hdr_len = hdr_size;
      r.body_len = cl;
      if ({32'h0, cnt} >= total) begin
        r.st = ST_COMPLETE;
        r.req_len = total[31:0];
        clear_frame();
      end else if (total > {32'h0, buf_limit}) begin
        r.st = ST_TOO_MUCH;
        clear_frame();
      end
      want_q.insert(want_q.size(), r);
    endfunction

    function void check_result(status_t st, logic [31:0] rl, logic [15:0] hl,
                               logic [63:0] bl);
      frame_result_t w;
      if (want_q.size() == 0) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("result beat with nothing expected: status %0d req %0d", st, rl);
        end
        return;
      end
      w = want_q.pop_front();
      if (w.st !== st || w.req_len !== rl || w.hdr_len !== hl || w.body_len !== bl) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected status %0d req %0d hdr %0d body %0d",
                   w.st, w.req_len, w.hdr_len, w.body_len);
          $display("          actual   status %0d req %0d hdr %0d body %0d",
                   st, rl, hl, bl);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  byte_in = 8'h0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  status;
  logic [31:0] request_length;
  logic [15:0] header_length;
  logic [63:0] body_length;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_MAX_HEADER;
  logic [31:0] cfg_data = 32'h0;

  framer_scoreboard sb;
  logic [7:0]       stream_q[$];
  int unsigned      cycles = 0;
  int               stall_left = 0;
  bit               calm = 1'b0;
  bit               gaps_on = 1'b1;

  http_request_framer dut (
    .clk            (clk),
    .rst            (rst),
    .byte_in        (byte_in),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .status         (status),
    .request_length (request_length),
    .header_length  (header_length),
    .body_length    (body_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls in bursts; none while cycles[7] is set or calm is on
  always @(posedge clk) begin
    if (rst || calm || cycles[7]) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status_t'(status), request_length, header_length, body_length);
  end

  function automatic void queue_byte(logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  function automatic void push_text(string s, bit mix_case);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (mix_case && ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - CASE_OFS;
      queue_byte(ch);
    end
  endfunction

  function automatic void push_crlf();
    queue_byte(CHAR_CR);
    queue_byte(CHAR_LF);
  endfunction

  // bytes 33 to 255: printable, DEL and high bytes, never CR, LF or blanks
  function automatic void push_token(int n);
    repeat (n) queue_byte(8'($urandom_range(33, 255)));
  endfunction

  function automatic void build_request();
    int clen;
    int v;
    clen = 0;
    push_token($urandom_range(1, 4));
    push_text(" /", 0);
    push_token($urandom_range(0, 3));
    push_crlf();
    repeat ($urandom_range(0, 2)) begin
      push_token($urandom_range(1, 5));
      push_text(": ", 0);
      push_token($urandom_range(0, 5));
      push_crlf();
    end
    if ($urandom_range(0, 5) != 0) begin
      case ($urandom_range(0, 9))
        0: begin
          push_text("content-lenx: 3", 0);   // near miss, not a key
          push_crlf();
        end
        1: queue_byte("c");                 // doubled first letter
        default: ;
      endcase
      push_text("content-length:", 1);
      repeat ($urandom_range(0, 2)) queue_byte($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
      case ($urandom_range(0, 9))
        0: ;                                          // key without digits
        1: push_text("x1", 0);
        2: begin
          push_text("18446744073709551615", 0);       // sum saturates
          clen = -1;
        end
        3: push_text("99999999999999999999", 0);      // overflows to zero
        4: begin
          push_text("007", 0);
          clen = 7;
        end
        default: begin
          v = $urandom_range(0, 24);
          push_text($sformatf("%0d", v), 0);
          clen = v;
        end
      endcase
      if ($urandom_range(0, 3) == 0) push_text(" ;z", 0);
      push_crlf();
      if ($urandom_range(0, 4) == 0) begin
        push_text("Content-Length: 9", 0);            // later keys are ignored
        push_crlf();
      end
    end
    push_crlf();
    if (clen > 0) repeat (clen) queue_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_noise();
    case ($urandom_range(0, 3))
      0: begin
        push_crlf();
        push_crlf();
      end
      1: begin
        push_crlf();
        queue_byte(CHAR_CR);
        push_token(2);
      end
      default: begin
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 3))
            0: queue_byte(CHAR_CR);
            1: queue_byte(CHAR_LF);
            default: queue_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    endcase
  endfunction

  task automatic send_stream();
    logic [7:0] b;
    while (stream_q.size() != 0) begin
      b = stream_q.pop_front();
      if ($urandom_range(0, 63) == 0) gaps_on = !gaps_on;
      if (!calm && gaps_on && $urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      byte_in <= b;
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      sb.note_byte(b);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_limits(logic [15:0] hdr, logic [31:0] buf_lim);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_HEADER;
    cfg_data <= {16'h0, hdr};
    @(posedge clk);
    cfg_index <= CFG_MAX_BUFFERED;
    cfg_data <= buf_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.hdr_limit = hdr;
    sb.buf_limit = buf_lim;
  endtask

  task automatic run_phase(logic [15:0] hdr, logic [31:0] buf_lim, int n, bit noise_only);
    apply_limits(hdr, buf_lim);
    while (stream_q.size() < n) begin
      if (noise_only || $urandom_range(0, 7) == 0) build_noise();
      else build_request();
    end
    send_stream();
    wait_idle();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header exactly at the limit, then one byte over it
    apply_limits(16'd4, 32'd1048576);
    push_crlf();
    push_crlf();
    queue_byte(8'h00);
    queue_byte(8'hFF);
    push_crlf();
    queue_byte(CHAR_CR);
    send_stream();
    wait_idle();
    // upper-case key, declared body beyond the buffer limit
    apply_limits(16'd40, 32'd4);
    push_text("CONTENT-LENGTH:9", 0);
    push_crlf();
    push_crlf();
    send_stream();
    wait_idle();

    run_phase(16'd8192, 32'd1048576, 300, 1'b0);
    run_phase(16'hFFFF, 32'hFFFF_FFFF, 250, 1'b0);
    run_phase(16'($urandom_range(24, 60)), 32'($urandom_range(20, 90)), 300, 1'b0);
    run_phase(16'd4, 32'd4, 60, 1'b1);
    run_phase(16'($urandom_range(40, 300)), $urandom, 200, 1'b0);
    calm = 1'b1;
    run_phase(16'd8192, 32'd200, 200, 1'b0);

    repeat (10) @(posedge clk);
    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
